>>> rtl/uf_pkg.sv
// uf_pkg: shared constants, operation codes and item types of the union-find engine
// no dependencies; used by uf_core and union_find_engine

package uf_pkg;

   localparam int NODE_W    = 10;
   localparam int MAX_NODES = 1024;
   localparam int ADDR_W    = $clog2(MAX_NODES);
   localparam int OP_W      = 2;

   localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
   localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
   localparam logic [OP_W-1:0] OP_UNION = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] root;
      logic              merged;
      logic              bad_node;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

>>> rtl/uf_core.sv
// uf_core: sequencer and parent table of the union-find engine
// one shared equality compare drives every walk decision; depends on uf_pkg

module uf_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  uf_pkg::req_type           req,
   input  logic [uf_pkg::NODE_W-1:0] node_count,
   input  logic                      take,
   output uf_pkg::status_type        status,
   output uf_pkg::rsp_type           result
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_CHK   = 3'd3;
   localparam logic [2:0] S_CRD   = 3'd4;
   localparam logic [2:0] S_CWR   = 3'd5;
   localparam logic [2:0] S_MERGE = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [uf_pkg::ADDR_W-1:0] cur_ff, cur_in;
   logic [uf_pkg::ADDR_W-1:0] start_ff, start_in;
   logic [uf_pkg::ADDR_W-1:0] top_ff, top_in;
   logic [uf_pkg::ADDR_W-1:0] ra_ff, ra_in;
   logic [uf_pkg::ADDR_W-1:0] nodeb_ff, nodeb_in;
   logic                      union_ff, union_in;
   logic                      second_ff, second_in;
   uf_pkg::rsp_type           res_ff, res_in;

   logic [uf_pkg::ADDR_W-1:0] parent_mem [uf_pkg::MAX_NODES];
   logic [uf_pkg::ADDR_W-1:0] rd_data_ff;
   logic [uf_pkg::ADDR_W-1:0] rd_addr;
   logic                      wr_en;
   logic [uf_pkg::ADDR_W-1:0] wr_addr;
   logic [uf_pkg::ADDR_W-1:0] wr_data;

   logic [uf_pkg::ADDR_W-1:0] cmp_x, cmp_y;
   logic                      cmp_eq;
   logic [uf_pkg::NODE_W-1:0] limit;
   logic                      a_ok, b_ok;

   assign limit = (32'(node_count) > uf_pkg::MAX_NODES - 1) ?
                  uf_pkg::NODE_W'(uf_pkg::MAX_NODES - 1) : node_count;
   assign a_ok  = (req.node_a != '0) && (req.node_a <= limit);
   assign b_ok  = (req.node_b != '0) && (req.node_b <= limit);

   // the one comparator, steered by the sequencer state
   always_comb begin
      unique case (state_ff)
         S_CHK: begin
            cmp_x = rd_data_ff;
            cmp_y = cur_ff;
         end
         S_MERGE: begin
            cmp_x = ra_ff;
            cmp_y = top_ff;
         end
         S_INIT: begin
            cmp_x = cur_ff;
            cmp_y = uf_pkg::ADDR_W'(limit);
         end
         default: begin
            cmp_x = cur_ff;
            cmp_y = top_ff;
         end
      endcase
   end
   assign cmp_eq = (cmp_x == cmp_y);

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      start_in  = start_ff;
      top_in    = top_ff;
      ra_in     = ra_ff;
      nodeb_in  = nodeb_ff;
      union_in  = union_ff;
      second_in = second_ff;
      res_in    = res_ff;
      rd_addr   = cur_ff;
      wr_en     = 1'b0;
      wr_addr   = cur_ff;
      wr_data   = top_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_in    = '0;
               union_in  = (req.op == uf_pkg::OP_UNION);
               second_in = 1'b0;
               nodeb_in  = uf_pkg::ADDR_W'(req.node_b);
               case (req.op)
                  uf_pkg::OP_INIT: begin
                     if (limit == '0) begin
                        state_in = S_DONE;
                     end else begin
                        cur_in   = uf_pkg::ADDR_W'(1);
                        state_in = S_INIT;
                     end
                  end
                  uf_pkg::OP_FIND: begin
                     if (a_ok) begin
                        cur_in   = uf_pkg::ADDR_W'(req.node_a);
                        start_in = uf_pkg::ADDR_W'(req.node_a);
                        state_in = S_RD;
                     end else begin
                        res_in.bad_node = 1'b1;
                        state_in        = S_DONE;
                     end
                  end
                  uf_pkg::OP_UNION: begin
                     if (a_ok && b_ok) begin
                        cur_in   = uf_pkg::ADDR_W'(req.node_a);
                        start_in = uf_pkg::ADDR_W'(req.node_a);
                        state_in = S_RD;
                     end else begin
                        res_in.bad_node = 1'b1;
                        state_in        = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INIT: begin
            wr_en   = 1'b1;
            wr_data = cur_ff;
            if (cmp_eq) begin
               state_in = S_DONE;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            // first pass: follow parents, one read per cycle
            if (cmp_eq) begin
               top_in   = cur_ff;
               cur_in   = start_ff;
               state_in = S_CRD;
            end else begin
               rd_addr = rd_data_ff;
               cur_in  = rd_data_ff;
            end
         end
         S_CRD: begin
            if (cmp_eq) begin
               // walk done, root in top_ff
               if (!union_ff) begin
                  res_in.root = uf_pkg::NODE_W'(top_ff);
                  state_in    = S_DONE;
               end else if (!second_ff) begin
                  ra_in     = top_ff;
                  second_in = 1'b1;
                  cur_in    = nodeb_ff;
                  start_in  = nodeb_ff;
                  state_in  = S_RD;
               end else begin
                  state_in = S_MERGE;
               end
            end else begin
               state_in = S_CWR;
            end
         end
         S_CWR: begin
            // second pass: point this node at the root, move on to its old parent
            wr_en    = 1'b1;
            cur_in   = rd_data_ff;
            state_in = S_CRD;
         end
         S_MERGE: begin
            res_in.root = uf_pkg::NODE_W'(ra_ff);
            if (!cmp_eq) begin
               wr_en         = 1'b1;
               wr_addr       = top_ff;
               wr_data       = ra_ff;
               res_in.merged = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         parent_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= parent_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         union_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         union_ff  <= union_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      start_ff <= start_in;
      top_ff   <= top_in;
      ra_ff    <= ra_in;
      nodeb_ff <= nodeb_in;
      res_ff   <= res_in;
   end

   assign status.idle = (state_ff == S_IDLE);
   assign status.done = (state_ff == S_DONE);
   assign result      = res_ff;

endmodule

>>> rtl/union_find_engine.sv
// union_find_engine: a find walks to the root, then again to point each walked node at it;
// a union does so for node_a, then node_b, and links root b under root a; init points nodes
// 1 to node_count at themselves; a bad node or unknown operation goes straight to the result;
// the parent table and its one compare set the pace; a new item is taken while a result
// waits in the output register; reset (synchronous) clears the sequencer and output valid and
// sets node_count to 1023; parent table contents are undefined until an init item

module union_find_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // node_a[9:0], node_b[19:10], zero pad
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // root[9:0], merged[10], bad_node[11], zero pad
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data  // node_count
);

   logic [uf_pkg::NODE_W-1:0] node_count_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   uf_pkg::rsp_type           rsp_ff, rsp_in;
   uf_pkg::req_type           req;
   uf_pkg::status_type        status;
   uf_pkg::rsp_type           result;
   logic                      start;
   logic                      take;

   assign req.op     = req_tuser;
   assign req.node_a = req_tdata[9:0];
   assign req.node_b = req_tdata[19:10];

   assign req_tready = status.idle;
   assign start      = req_tvalid && req_tready;
   assign take       = status.done && (!rsp_valid_ff || rsp_tready);

   uf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req),
      .node_count (node_count_ff),
      .take       (take),
      .status     (status),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 10'd1023;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.bad_node, rsp_ff.merged, rsp_ff.root};

endmodule

>>> rtl/uf_checker.sv
// uf_checker: port-level assertions for union_find_engine, attached by bind
// sees only the top-level ports

module uf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a bad node never reports a root or a merge
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |-> rsp_tdata[9:0] == 10'd0 && !rsp_tdata[10])
      else $error("bad node result carries data");

   // a merge always names a real root
   a_merge_root: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[9:0] != 10'd0 && !rsp_tdata[11])
      else $error("merge without root");

   // an accepted item keeps the engine busy the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind union_find_engine uf_checker u_uf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
